// ----- design/printable_shift_stream_cipher_assert.svh -----
// Assertion macros for the printable shift stream cipher.
`ifndef PRINTABLE_SHIFT_STREAM_CIPHER_ASSERT_SVH
`define PRINTABLE_SHIFT_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PSSC_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("pssc assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PSSC_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("pssc assertion failed");

`endif

// ----- design/pssc_pkg.sv -----
// Types and constants shared by the printable shift stream cipher.
`timescale 1ns / 1ps
`default_nettype none
package pssc_pkg;
	localparam int MAX_GENERATORS = 10;
	localparam int MT_WORDS       = 624;
	localparam int MT_SHIFT       = 397;
	localparam int ALPHABET_SIZE  = 95;
	localparam int RED_STEPS      = 9;
	localparam int MOD_STEPS      = 8;

	localparam logic [7:0]  FIRST_PRINT = 8'd32;
	localparam logic [7:0]  LAST_PRINT  = 8'd126;
	localparam logic [31:0] INIT_MULT   = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX   = 32'h9908b0df;

	localparam logic [1:0] OP_KEY  = 2'd0;
	localparam logic [1:0] OP_SEED = 2'd1;
	localparam logic [1:0] OP_TEXT = 2'd2;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_SEED = 1'b1;

	localparam logic [8:0] LANE_BASE [MAX_GENERATORS] = '{
		9'd307, 9'd311, 9'd313, 9'd317, 9'd331,
		9'd337, 9'd347, 9'd349, 9'd353, 9'd359
	};
	localparam logic [29:0] LANE_MOD [MAX_GENERATORS] = '{
		30'd1000000007, 30'd1000000009, 30'd1000000021, 30'd1000000033,
		30'd1000000087, 30'd1000000093, 30'd1000000097, 30'd1000000103,
		30'd1000000123, 30'd1000000181
	};

	typedef logic [9:0] idx_t;

	typedef struct packed {
		logic latch;
		logic hash_mul;
		logic hash_red;
		logic hash_last;
		logic seed_first;
		logic seed_step;
		logic rd_a;
		logic rd_b;
		logic rd_c;
		logic twist;
		logic mod_step;
		logic load_out;
		logic out_kind;
		idx_t step;
	} pssc_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       key_ok;
		logic       printable;
		logic       out_free;
	} pssc_sts_t;
endpackage
`default_nettype wire

// ----- design/pssc_ifs.sv -----
// Request channel interfaces: text input, result output, configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface pssc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_char;
	modport source (output valid, output op, output data_char, input ready);
	modport sink (input valid, input op, input data_char, output ready);
endinterface

interface pssc_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] out_char;
	logic       bad_char;
	modport source (output valid, output kind, output out_char, output bad_char, input ready);
	modport sink (input valid, input kind, input out_char, input bad_char, output ready);
endinterface

interface pssc_cfg_if;
	logic valid;
	logic ready;
	logic encrypt_mode;
	modport source (output valid, output encrypt_mode, input ready);
	modport sink (input valid, input encrypt_mode, output ready);
endinterface
`default_nettype wire

// ----- design/pssc_datapath.sv -----
// Datapath: hash lanes, generator memories, twist and temper, mod 95, output register.
`timescale 1ns / 1ps
`default_nettype none
module pssc_datapath import pssc_pkg::*; #(
	parameter int GENERATORS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pssc_cmd_t  cmd,
	output pssc_sts_t  sts,
	input  logic [1:0] op,
	input  logic [7:0] data_char,
	input  logic       encrypt_mode,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       kind,
	output logic [7:0] out_char,
	output logic       bad_char
);
	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 11);
		t = t ^ ((t << 7) & 32'h9d2c5680);
		t = t ^ ((t << 15) & 32'hefc60000);
		t = t ^ (t >> 18);
		return t;
	endfunction

	logic [7:0]  ch_q;
	idx_t        idx_q;
	logic [31:0] x_q;
	logic [6:0]  rem_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  out_char_q;
	logic        bad_q;

	idx_t        idx_p1, idx_p397, raddr, waddr;
	logic [10:0] sum397;
	logic [3:0]  red_sh;
	logic        rd_en, wr_en;
	logic [31:0] tempered [GENERATORS];
	logic [31:0] x_all;
	logic [6:0]  rem_nxt;
	logic [6:0]  k;
	logic [7:0]  shifted;
	logic        ch_bad;

	assign sum397   = {1'b0, idx_q} + 11'(MT_SHIFT);
	assign idx_p1   = (idx_q == idx_t'(MT_WORDS - 1)) ? '0 : idx_q + 10'd1;
	assign idx_p397 = (sum397 >= 11'(MT_WORDS)) ? 10'(sum397 - 11'(MT_WORDS)) : sum397[9:0];
	assign raddr    = cmd.rd_a ? idx_q : (cmd.rd_b ? idx_p1 : idx_p397);
	assign waddr    = cmd.twist ? idx_q : (cmd.seed_first ? '0 : cmd.step);
	assign rd_en    = cmd.rd_a | cmd.rd_b | cmd.rd_c;
	assign wr_en    = cmd.seed_first | cmd.seed_step | cmd.twist;
	assign red_sh   = 4'(RED_STEPS - 1) - cmd.step[3:0];

	for (genvar g = 0; g < GENERATORS; g++) begin : g_lane
		logic [29:0] lane_q;
		logic [38:0] red_q;
		logic [38:0] mod_sh, red_nxt;
		logic [31:0] mem [MT_WORDS];
		logic [31:0] rd_q, wi_q, wn_q, prev_q;
		logic [31:0] mix, seed_v, y, twist_v, wdata;

		assign mod_sh  = {9'd0, LANE_MOD[g]} << red_sh;
		assign red_nxt = (red_q >= mod_sh) ? red_q - mod_sh : red_q;
		assign mix     = prev_q ^ (prev_q >> 30);
		assign seed_v  = INIT_MULT * mix + {22'd0, cmd.step};
		assign y       = {wi_q[31], wn_q[30:0]};
		assign twist_v = rd_q ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
		assign wdata   = cmd.twist ? twist_v : (cmd.seed_first ? {2'b00, lane_q} : seed_v);
		assign tempered[g] = temper(twist_v);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lane_q <= '0;
			end else if (cmd.seed_first) begin
				lane_q <= '0;
			end else if (cmd.hash_red && cmd.hash_last) begin
				lane_q <= red_nxt[29:0];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.hash_mul) begin
				red_q <= 39'(lane_q) * 39'(LANE_BASE[g]) + 39'(ch_q);
			end else if (cmd.hash_red) begin
				red_q <= red_nxt;
			end
			if (cmd.seed_first) begin
				prev_q <= {2'b00, lane_q};
			end else if (cmd.seed_step) begin
				prev_q <= seed_v;
			end
			if (cmd.rd_b) begin
				wi_q <= rd_q;
			end
			if (cmd.rd_c) begin
				wn_q <= rd_q;
			end
		end

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[waddr] <= wdata;
			end
			if (rd_en) begin
				rd_q <= mem[raddr];
			end
		end
	end

	always_comb begin
		x_all = '0;
		for (int g = 0; g < GENERATORS; g++) begin
			x_all = x_all ^ tempered[g];
		end
	end

	// Four quotient bits per step, top nibble first.
	always_comb begin
		logic [7:0] t;
		rem_nxt = rem_q;
		for (int b = 0; b < 4; b++) begin
			t = {rem_nxt, x_q[31 - b]};
			if (t >= 8'(ALPHABET_SIZE)) begin
				t = t - 8'(ALPHABET_SIZE);
			end
			rem_nxt = t[6:0];
		end
	end

	always_comb begin
		k = 7'(ch_q - FIRST_PRINT);
		if (encrypt_mode) begin
			shifted = {1'b0, k} + {1'b0, rem_q};
		end else begin
			shifted = {1'b0, k} + 8'(ALPHABET_SIZE) - {1'b0, rem_q};
		end
		if (shifted >= 8'(ALPHABET_SIZE)) begin
			shifted = shifted - 8'(ALPHABET_SIZE);
		end
		shifted = shifted + FIRST_PRINT;
	end

	assign ch_bad = (ch_q < FIRST_PRINT) || (ch_q > LAST_PRINT);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ch_q <= data_char;
		end
		if (cmd.twist) begin
			x_q   <= x_all;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			x_q   <= x_q << 4;
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.seed_first) begin
			idx_q <= '0;
		end else if (cmd.twist) begin
			idx_q <= idx_p1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q <= cmd.out_kind;
			if (cmd.out_kind == KIND_SEED) begin
				out_char_q <= '0;
				bad_q      <= 1'b0;
			end else if (ch_bad) begin
				out_char_q <= ch_q;
				bad_q      <= 1'b1;
			end else begin
				out_char_q <= shifted;
				bad_q      <= 1'b0;
			end
		end
	end

	assign sts.op        = op;
	assign sts.key_ok    = !data_char[7];
	assign sts.printable = (data_char >= FIRST_PRINT) && (data_char <= LAST_PRINT);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_char  = out_char_q;
	assign bad_char  = bad_q;
endmodule
`default_nettype wire

// ----- design/pssc_ctrl.sv -----
// Controller state machine sequencing hash, seed, draw and output steps.
`timescale 1ns / 1ps
`default_nettype none
module pssc_ctrl import pssc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pssc_sts_t sts,
	output pssc_cmd_t cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HMUL  = 4'd1;
	localparam logic [3:0] S_HRED  = 4'd2;
	localparam logic [3:0] S_SEED0 = 4'd3;
	localparam logic [3:0] S_SEED  = 4'd4;
	localparam logic [3:0] S_RDA   = 4'd5;
	localparam logic [3:0] S_RDB   = 4'd6;
	localparam logic [3:0] S_RDC   = 4'd7;
	localparam logic [3:0] S_TWIST = 4'd8;
	localparam logic [3:0] S_MOD   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q, state_nxt;
	idx_t       cnt_q, cnt_nxt;
	logic       kind_q, kind_nxt;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		kind_nxt  = kind_q;
		cmd       = '0;
		cmd.latch    = accept;
		cmd.step     = cnt_q;
		cmd.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_nxt = (sts.op == OP_SEED) ? KIND_SEED : KIND_TEXT;
					unique case (sts.op)
						OP_KEY:  state_nxt = sts.key_ok ? S_HMUL : S_IDLE;
						OP_SEED: state_nxt = S_SEED0;
						OP_TEXT: state_nxt = sts.printable ? S_RDA : S_DONE;
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			S_HMUL: begin
				cmd.hash_mul = 1'b1;
				cnt_nxt      = '0;
				state_nxt    = S_HRED;
			end
			S_HRED: begin
				cmd.hash_red = 1'b1;
				if (cnt_q == idx_t'(RED_STEPS - 1)) begin
					cmd.hash_last = 1'b1;
					state_nxt     = S_IDLE;
				end else begin
					cnt_nxt = cnt_q + 10'd1;
				end
			end
			S_SEED0: begin
				cmd.seed_first = 1'b1;
				cnt_nxt        = 10'd1;
				state_nxt      = S_SEED;
			end
			S_SEED: begin
				cmd.seed_step = 1'b1;
				if (cnt_q == idx_t'(MT_WORDS - 1)) begin
					state_nxt = S_DONE;
				end else begin
					cnt_nxt = cnt_q + 10'd1;
				end
			end
			S_RDA: begin
				cmd.rd_a  = 1'b1;
				state_nxt = S_RDB;
			end
			S_RDB: begin
				cmd.rd_b  = 1'b1;
				state_nxt = S_RDC;
			end
			S_RDC: begin
				cmd.rd_c  = 1'b1;
				state_nxt = S_TWIST;
			end
			S_TWIST: begin
				cmd.twist = 1'b1;
				cnt_nxt   = '0;
				state_nxt = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (cnt_q == idx_t'(MOD_STEPS - 1)) begin
					state_nxt = S_DONE;
				end else begin
					cnt_nxt = cnt_q + 10'd1;
				end
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			kind_q  <= KIND_TEXT;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			kind_q  <= kind_nxt;
		end
	end
endmodule
`default_nettype wire

// ----- design/printable_shift_stream_cipher.sv -----
// Key byte: multiply, then nine compare-subtract steps per hash lane.
// Seed item: one generator word per cycle; word 0 is the hash lane, the rest come from the init multiplier.
// Printable text byte: three memory reads, twist, eight mod-95 steps, output.
// Non-printable text byte: straight to output. One request at a time; the result register frees
// the input side. Reset clears hash lanes, index, mode and control; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "printable_shift_stream_cipher_assert.svh"
module printable_shift_stream_cipher import pssc_pkg::*; #(
	parameter int GENERATORS = 10
) (
	input logic        clk,
	input logic        arst_n,
	pssc_in_if.sink    text_in,
	pssc_out_if.source result,
	pssc_cfg_if.sink   cfg
);
	pssc_cmd_t cmd;
	pssc_sts_t sts;
	logic      encrypt_mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encrypt_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			encrypt_mode_q <= cfg.encrypt_mode;
		end
	end

	pssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pssc_datapath #(
		.GENERATORS (GENERATORS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (text_in.op),
		.data_char    (text_in.data_char),
		.encrypt_mode (encrypt_mode_q),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.kind         (result.kind),
		.out_char     (result.out_char),
		.bad_char     (result.bad_char)
	);

	`PSSC_ASSERT_NEXT(a_seed_starts, text_in.valid && text_in.ready && text_in.op == OP_SEED, cmd.seed_first)
	`PSSC_ASSERT_NOW(a_load_when_free, cmd.load_out, !result.valid || result.ready)
	`PSSC_ASSERT_NEXT(a_text_busy, text_in.valid && text_in.ready && text_in.op == OP_TEXT, !text_in.ready)
endmodule
`default_nettype wire

// ----- sim/tb_pssc_ifs.sv -----
// Testbench types for the cipher: the expected result record.
`timescale 1ns / 1ps
package tb_pssc_pkg;
	typedef struct packed {
		logic       kind;
		logic [7:0] out_char;
		logic       bad_char;
	} cipher_res_t;
endpackage

// ----- sim/tb_top.sv -----
// Testbench for the printable shift stream cipher: predicts keystream shifts and checks results.
`timescale 1ns / 1ps
module tb_top;
	import pssc_pkg::*;
	import tb_pssc_pkg::*;

	localparam int NGEN = 10;
	localparam int WATCH_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 700;

	logic clk;
	logic arst_n;

	pssc_in_if  text_in ();
	pssc_out_if result ();
	pssc_cfg_if cfg ();

	printable_shift_stream_cipher #(.GENERATORS(NGEN)) dut (
		.clk(clk), .arst_n(arst_n), .text_in(text_in), .result(result), .cfg(cfg)
	);

	// predictor state
	logic [29:0] lane_hash [NGEN];
	logic [31:0] mt_state [NGEN][MT_WORDS];
	int unsigned draw_pos;
	logic        fwd_mode;

	cipher_res_t expected_q[$];
	int  mismatches;
	int  idle_cycles;
	logic long_hold;
	int  gap_max;

	localparam logic [31:0] LANE_BASE_TB [NGEN] = '{307, 311, 313, 317, 331, 337, 347, 349, 353, 359};
	localparam logic [31:0] LANE_MOD_TB [NGEN] = '{1000000007, 1000000009, 1000000021,
		1000000033, 1000000087, 1000000093, 1000000097, 1000000103, 1000000123, 1000000181};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] draw_word(int g, int unsigned i);
		logic [31:0] y;
		logic [31:0] v;
		y = (mt_state[g][i] & 32'h80000000) | (mt_state[g][(i + 1) % MT_WORDS] & 32'h7fffffff);
		v = mt_state[g][(i + 397) % MT_WORDS] ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'h0);
		mt_state[g][i] = v;
		v ^= v >> 11;
		v ^= (v << 7) & 32'h9d2c5680;
		v ^= (v << 15) & 32'hefc60000;
		v ^= v >> 18;
		return v;
	endfunction

	function automatic void queue_expected(input cipher_res_t r);
		expected_q = {expected_q, r};
	endfunction

	task automatic predict_cipher(input logic [1:0] op, input logic [7:0] ch);
		cipher_res_t r;
		logic [31:0] x;
		logic [63:0] t;
		int unsigned rd, k, pos;
		if (op == OP_KEY) begin
			if (ch <= 8'd127)
				for (int g = 0; g < NGEN; g++) begin
					t = 64'(lane_hash[g]) * 64'(LANE_BASE_TB[g]) + 64'(ch);
					lane_hash[g] = 30'(t % 64'(LANE_MOD_TB[g]));
				end
		end else if (op == OP_SEED) begin
			for (int g = 0; g < NGEN; g++) begin
				mt_state[g][0] = 32'(lane_hash[g]);
				for (int i = 1; i < MT_WORDS; i++)
					mt_state[g][i] = 32'd1812433253 *
						(mt_state[g][i - 1] ^ (mt_state[g][i - 1] >> 30)) + 32'(i);
				lane_hash[g] = '0;
			end
			draw_pos = 0;
			r.kind = KIND_SEED; r.out_char = '0; r.bad_char = 1'b0;
			queue_expected(r);
		end else if (op == OP_TEXT) begin
			r.kind = KIND_TEXT;
			if (ch < 8'd32 || ch > 8'd126) begin
				r.out_char = ch; r.bad_char = 1'b1;
			end else begin
				x = '0;
				for (int g = 0; g < NGEN; g++) x ^= draw_word(g, draw_pos);
				draw_pos = (draw_pos + 1) % MT_WORDS;
				rd = x % 95;
				k = ch - 32;
				pos = fwd_mode ? (k + rd) % 95 : (k + 95 - rd) % 95;
				r.out_char = 8'(pos + 32); r.bad_char = 1'b0;
			end
			queue_expected(r);
		end
	endtask

	// sender: bursts with random gaps; valid drops only during a gap or while draining
	int burst_left;
	task automatic send_request(input logic [1:0] op, input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				text_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_in.valid <= 1'b1;
		text_in.op <= op;
		text_in.data_char <= ch;
		predict_cipher(op, ch);
		do @(posedge clk); while (!text_in.ready);
	endtask

	task automatic wait_drained();
		text_in.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg.valid <= 1'b1;
		cfg.encrypt_mode <= m;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		fwd_mode = m;
	endtask

	task automatic send_key(input int len, input logic wide);
		for (int i = 0; i < len; i++)
			send_request(OP_KEY, wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126)));
	endtask

	task automatic test_directed();
		logic [7:0] edge_chars [8] = '{8'd0, 8'd31, 8'd32, 8'd126, 8'd127, 8'd255, 8'd65, 8'd128};
		// text before seeding is outside the contract, so seed first
		send_request(OP_KEY, 8'd0);
		send_request(OP_KEY, 8'd127);
		send_request(OP_KEY, 8'd128);
		send_request(OP_KEY, 8'd255);
		send_request(OP_SEED, 8'd0);
		foreach (edge_chars[i]) send_request(OP_TEXT, edge_chars[i]);
		send_request(2'd3, 8'hff);
		send_request(OP_SEED, 8'hff);
		send_request(OP_TEXT, 8'd126);
		send_request(OP_TEXT, 8'd32);
		wait_drained();
	endtask

	task automatic test_mode(input logic m, input int n_items);
		int r;
		write_mode(m);
		send_key($urandom_range(0, 4), 1'b1);
		send_request(OP_SEED, 8'($urandom));
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80) send_request(OP_TEXT, 8'($urandom_range(32, 126)));
			else if (r < 88) send_request(OP_TEXT, 8'($urandom));
			else if (r < 96) send_request(OP_KEY, 8'($urandom));
			else if (r < 98) send_request(2'd3, 8'($urandom));
			else send_request(OP_SEED, 8'($urandom));
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		long_hold = 1'b1;
		for (int i = 0; i < 20; i++) send_request(OP_TEXT, 8'($urandom_range(32, 126)));
		wait_drained();
	endtask

	// receiver stall pattern and long hold-off
	int hold_count;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_count <= 0;
		end else if (long_hold) begin
			result.ready <= 1'b0;
			if (hold_count == 400) begin
				long_hold <= 1'b0;
				hold_count <= 0;
			end else begin
				hold_count <= hold_count + 1;
			end
		end else begin
			result.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		cipher_res_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result kind=%0d char=%0d bad=%0d", $time,
					result.kind, result.out_char, result.bad_char);
				mismatches++;
			end else begin
				e = expected_q.pop_front();
				if (e.kind !== result.kind || e.out_char !== result.out_char ||
						e.bad_char !== result.bad_char) begin
					$display("%0t: expected kind=%0d char=%0d bad=%0d, got kind=%0d char=%0d bad=%0d",
						$time, e.kind, e.out_char, e.bad_char,
						result.kind, result.out_char, result.bad_char);
					mismatches++;
				end
			end
		end
	end

	// watchdog on accepted requests, config writes or results
	always @(posedge clk) begin
		if ((text_in.valid && text_in.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		long_hold = 1'b0;
		burst_left = 0;
		gap_max = 6;
		draw_pos = 0;
		fwd_mode = 1'b0;
		foreach (lane_hash[g]) lane_hash[g] = '0;
		text_in.valid = 1'b0;
		text_in.op = OP_KEY;
		text_in.data_char = '0;
		cfg.valid = 1'b0;
		cfg.encrypt_mode = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mode(1'b1, 380);
		gap_max = 0;
		test_mode(1'b0, 380);
		gap_max = 6;
		test_backpressure();
		test_mode(1'b1, 330);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
